/* sv/kcqf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kcqf_pkg
// Shared types and constants of the quality-filtered k-mer counter.
// ----------------------------------------------------------------------------
package kcqf_pkg;

	// fixed field widths
	localparam int KEY_W      = 64;
	localparam int CNT_W      = 32;
	localparam int QUAL_W     = 7;
	localparam int LEN_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int LANES      = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_QUAL_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAST_QUAL_THR = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WIN,
		ST_FILTER,
		ST_HASH,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_RESULT
	} state_t;

	// window status toward the sequencer
	typedef struct packed {
		logic full;
		logic done;
		logic pass;
	} win_stat_t;

	// one count table entry
	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cnt;
	} tbl_entry_t;

endpackage
`default_nettype wire

/* sv/kcqf_window.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kcqf_window
// Sliding base window with quality history and a lane-parallel filter that
// scans the window qualities eight at a time for sum and minimum.
// ----------------------------------------------------------------------------
module kcqf_window import kcqf_pkg::*; #(
	parameter int MAX_K = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic [1:0]                   base,
	input  wire logic [QUAL_W-1:0]            quality,
	input  wire logic                         read_start,
	input  wire logic [$clog2(MAX_K+1)-1:0]   k,
	input  wire logic                         start,
	input  wire logic [QUAL_W-1:0]            mean_thr,
	input  wire logic [QUAL_W-1:0]            least_thr,
	output logic      [KEY_W-1:0]             kmer,
	output win_stat_t                         stat
);

	localparam int KW     = $clog2(MAX_K+1);
	localparam int WK_W   = 2 * MAX_K;
	localparam int NCH    = (MAX_K + LANES - 1) / LANES;
	localparam int SCAN_N = NCH * LANES;
	localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int SUM_W  = $clog2(MAX_K * 127 + 1);
	localparam int PRD_W  = QUAL_W + KW;
	localparam int CMP_W  = (SUM_W > PRD_W) ? SUM_W : PRD_W;

	logic [WK_W-1:0]   key_q;
	logic [KW-1:0]     fill_q;
	logic [QUAL_W-1:0] qual_q [MAX_K];
	logic [QUAL_W-1:0] scan_q [SCAN_N];
	logic [CH_W-1:0]   chunk_q;
	logic              run_q;
	logic              fin_q;
	logic [SUM_W-1:0]  sum_q;
	logic [QUAL_W-1:0] min_q;
	logic [SUM_W-1:0]  sum_d;
	logic [QUAL_W-1:0] min_d;
	logic [KEY_W-1:0]  key_ext;
	logic [WK_W-1:0]   key_prev;

	// key and fill register
	assign key_prev = read_start ? '0 : key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			fill_q <= '0;
		end else if (push) begin
			key_q <= (key_prev << 2) | WK_W'(base);
			if (read_start) begin
				fill_q <= KW'(1);
			end else if (fill_q != KW'(MAX_K)) begin
				fill_q <= fill_q + KW'(1);
			end
		end
	end

	// quality history, newest at entry 0
	always_ff @(posedge clk) begin
		if (push) begin
			qual_q[0] <= quality;
			for (int i = 1; i < MAX_K; i++) begin
				qual_q[i] <= qual_q[i-1];
			end
		end
	end

	// masked k-mer of the last k bases
	assign key_ext = KEY_W'(key_q);

	always_comb begin
		for (int b = 0; b < KEY_W; b++) begin
			kmer[b] = key_ext[b] & ((b / 2) < int'(k));
		end
	end

	// lane sum and minimum of the current chunk
	always_comb begin
		sum_d = sum_q;
		min_d = min_q;
		for (int l = 0; l < LANES; l++) begin
			if (int'(chunk_q) * LANES + l < int'(k)) begin
				sum_d = sum_d + SUM_W'(scan_q[l]);
				if (scan_q[l] < min_d) begin
					min_d = scan_q[l];
				end
			end
		end
	end

	// filter scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
			chunk_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				chunk_q <= '0;
			end else if (run_q) begin
				if (chunk_q == CH_W'(NCH - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end else begin
					chunk_q <= chunk_q + CH_W'(1);
				end
			end
		end
	end

	// scan copy and accumulators
	always_ff @(posedge clk) begin
		if (start) begin
			sum_q <= '0;
			min_q <= '1;
			for (int i = 0; i < SCAN_N; i++) begin
				scan_q[i] <= (i < MAX_K) ? qual_q[(i < MAX_K) ? i : 0] : '0;
			end
		end else if (run_q) begin
			sum_q <= sum_d;
			min_q <= min_d;
			for (int i = 0; i < SCAN_N; i++) begin
				scan_q[i] <= (i + LANES < SCAN_N) ? scan_q[(i + LANES < SCAN_N) ? i + LANES : 0]
					: '0;
			end
		end
	end

	// floor(sum / k) >= thr is the same as sum >= thr * k
	always_comb begin
		stat.full = (fill_q >= k);
		stat.done = fin_q;
		stat.pass = (CMP_W'(sum_q) >= CMP_W'(PRD_W'(mean_thr) * PRD_W'(k)))
			&& (min_q >= least_thr);
	end

endmodule
`default_nettype wire

/* sv/kmer_counter_quality_filtered_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kmer_counter_quality_filtered_core
// Quality-filtered k-mer counter with a hashed count table in one memory.
// ----------------------------------------------------------------------------
// Usage: one base per input transaction (base, quality, read_start) on a
// valid/ready channel. Once k bases of the current read were seen, each base
// gives one output transaction (kmer, passed, count, dropped); before that no
// output is produced. Configuration is written through cfg_we / cfg_index /
// cfg_data while the block is idle.
// Flow: a base with no result goes from the window step back to idle. A
// counted k-mer takes the hash step, a read and a check per table probe,
// then the result step; a filter scan of the window qualities comes first
// if a quality threshold is set. Probes go linearly from a key hash over
// the single-port table; a full table and a new key cost TABLE_DEPTH probes.
// Reset: after arst_n the table memory is cleared one entry per cycle, with
// in_ready low.
// Stall: a finished result sits in the output register; the next base is
// accepted while it waits, and its own result waits until that one is taken.
// ----------------------------------------------------------------------------
module kmer_counter_quality_filtered_core import kcqf_pkg::*; #(
	parameter int MAX_K       = 32,
	parameter int TABLE_DEPTH = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            base,
	input  wire logic [QUAL_W-1:0]     quality,
	input  wire logic                  read_start,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [KEY_W-1:0]      kmer,
	output logic                       passed,
	output logic      [CNT_W-1:0]      count,
	output logic                       dropped
);

	localparam int KW     = $clog2(MAX_K+1);
	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	// configuration registers
	logic [LEN_W-1:0]  kmer_length_q;
	logic [QUAL_W-1:0] mean_thr_q;
	logic [QUAL_W-1:0] least_thr_q;
	logic [KW-1:0]     k_eff;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [ADDR_W-1:0] probes_q, probes_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic              res_pass_q, res_pass_d;
	logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;
	logic              res_drop_q, res_drop_d;
	logic              out_valid_q;
	logic              load_out;

	logic              win_push;
	logic              filt_start;
	logic [KEY_W-1:0]  win_kmer;
	win_stat_t         win_stat;

	logic [ADDR_W-1:0] hash_addr;
	logic [ADDR_W-1:0] hash_fold;

	tbl_entry_t        mem [TABLE_DEPTH];
	tbl_entry_t        rd_q;
	tbl_entry_t        mem_wdata;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_we;
	logic              rd_en;
	logic [CNT_W-1:0]  cnt_inc;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= LEN_W'(31);
			mean_thr_q    <= '0;
			least_thr_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KMER_LENGTH:    kmer_length_q <= cfg_data[LEN_W-1:0];
				CFG_MEAN_QUAL_THR:  mean_thr_q    <= cfg_data;
				CFG_LEAST_QUAL_THR: least_thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp k into 1..MAX_K
	assign k_eff = (kmer_length_q == '0) ? KW'(1)
		: (kmer_length_q > LEN_W'(MAX_K)) ? KW'(MAX_K) : KW'(kmer_length_q);

	kcqf_window #(
		.MAX_K (MAX_K)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (win_push),
		.base       (base),
		.quality    (quality),
		.read_start (read_start),
		.k          (k_eff),
		.start      (filt_start),
		.mean_thr   (mean_thr_q),
		.least_thr  (least_thr_q),
		.kmer       (win_kmer),
		.stat       (win_stat)
	);

	// xor fold of the key into a table address
	always_comb begin
		hash_fold = '0;
		for (int b = 0; b < KEY_W; b++) begin
			hash_fold[b % ADDR_W] = hash_fold[b % ADDR_W] ^ key_q[b];
		end
		if ({1'b0, hash_fold} >= (ADDR_W+1)'(TABLE_DEPTH)) begin
			hash_addr = hash_fold - ADDR_W'(TABLE_DEPTH);
		end else begin
			hash_addr = hash_fold;
		end
	end

	// count table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[addr_q];
		end
	end

	assign cnt_inc = (rd_q.cnt == '1) ? rd_q.cnt : rd_q.cnt + CNT_W'(1);

	// sequencer next state
	always_comb begin
		state_d    = state_q;
		clr_addr_d = clr_addr_q;
		addr_d     = addr_q;
		probes_d   = probes_q;
		key_d      = key_q;
		res_pass_d = res_pass_q;
		res_cnt_d  = res_cnt_q;
		res_drop_d = res_drop_q;
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wdata  = '0;
		rd_en      = 1'b0;
		win_push   = 1'b0;
		filt_start = 1'b0;
		load_out   = 1'b0;
		in_ready   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				if (clr_addr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end else begin
					clr_addr_d = clr_addr_q + ADDR_W'(1);
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					win_push = 1'b1;
					state_d  = ST_WIN;
				end
			end
			ST_WIN: begin
				if (!win_stat.full) begin
					state_d = ST_IDLE;
				end else begin
					key_d = win_kmer;
					if (mean_thr_q == '0 && least_thr_q == '0) begin
						state_d = ST_HASH;
					end else begin
						filt_start = 1'b1;
						state_d    = ST_FILTER;
					end
				end
			end
			ST_FILTER: begin
				if (win_stat.done) begin
					if (win_stat.pass) begin
						state_d = ST_HASH;
					end else begin
						res_pass_d = 1'b0;
						res_cnt_d  = '0;
						res_drop_d = 1'b0;
						state_d    = ST_RESULT;
					end
				end
			end
			ST_HASH: begin
				addr_d   = hash_addr;
				probes_d = '0;
				state_d  = ST_PROBE_RD;
			end
			ST_PROBE_RD: begin
				rd_en   = 1'b1;
				state_d = ST_PROBE_CHK;
			end
			ST_PROBE_CHK: begin
				if (rd_q.used && rd_q.key == key_q) begin
					mem_we     = 1'b1;
					mem_wdata  = '{used: 1'b1, key: key_q, cnt: cnt_inc};
					res_pass_d = 1'b1;
					res_cnt_d  = cnt_inc;
					res_drop_d = 1'b0;
					state_d    = ST_RESULT;
				end else if (!rd_q.used) begin
					mem_we     = 1'b1;
					mem_wdata  = '{used: 1'b1, key: key_q, cnt: CNT_W'(1)};
					res_pass_d = 1'b1;
					res_cnt_d  = CNT_W'(1);
					res_drop_d = 1'b0;
					state_d    = ST_RESULT;
				end else if (probes_q == ADDR_W'(TABLE_DEPTH - 1)) begin
					res_pass_d = 1'b0;
					res_cnt_d  = '0;
					res_drop_d = 1'b1;
					state_d    = ST_RESULT;
				end else begin
					probes_d = probes_q + ADDR_W'(1);
					addr_d   = (addr_q == ADDR_W'(TABLE_DEPTH - 1)) ? '0
						: addr_q + ADDR_W'(1);
					state_d  = ST_PROBE_RD;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q    <= state_d;
			clr_addr_q <= clr_addr_d;
		end
	end

	// probe and result working registers
	always_ff @(posedge clk) begin
		addr_q     <= addr_d;
		probes_q   <= probes_d;
		key_q      <= key_d;
		res_pass_q <= res_pass_d;
		res_cnt_q  <= res_cnt_d;
		res_drop_q <= res_drop_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kmer    <= key_q;
			passed  <= res_pass_q;
			count   <= res_cnt_q;
			dropped <= res_drop_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
